// ===== rtl/assert_macros.svh =====
// assertion macros used by the deframer core
// each macro takes a label, the clock, the active-low reset and the checked terms
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// a property that must hold at every edge outside reset
`define WSD_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("wsd assertion failed");

// a condition that must be followed by another one at the next edge
`define WSD_ASSERT_NEXT(lbl, clk, rst_n, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("wsd assertion failed");

`else

`define WSD_ASSERT(lbl, clk, rst_n, prop)
`define WSD_ASSERT_NEXT(lbl, clk, rst_n, pre, post)

`endif

`endif

// ===== rtl/wsd_pkg.sv =====
package wsd_pkg;

    // width of the frame length and payload counter
    localparam int LENGTH_BITS = 64;

    // result kinds
    typedef enum logic [1:0] {
        KIND_PAYLOAD  = 2'd0,
        KIND_BOUNDARY = 2'd1,
        KIND_PONG     = 2'd2,
        KIND_CLOSE    = 2'd3
    } kind_t;

    // frame opcodes that the parser acts on
    localparam logic [3:0] OP_CONT  = 4'h0;
    localparam logic [3:0] OP_TEXT  = 4'h1;
    localparam logic [3:0] OP_CLOSE = 4'h8;
    localparam logic [3:0] OP_PING  = 4'h9;

    // seven-bit length codes that select an extended length
    localparam logic [6:0] LEN7_EXT16 = 7'd126;
    localparam logic [6:0] LEN7_EXT64 = 7'd127;

    // byte counts of the extended length and the mask key
    localparam logic [3:0] EXT16_BYTES = 4'd2;
    localparam logic [3:0] EXT64_BYTES = 4'd8;
    localparam logic [3:0] KEY_BYTES   = 4'd4;

    // parser phase, one-hot
    typedef enum logic [5:0] {
        PH_HDR0   = 6'b000001,
        PH_HDR1   = 6'b000010,
        PH_EXT    = 6'b000100,
        PH_KEY    = 6'b001000,
        PH_DATA   = 6'b010000,
        PH_CLOSED = 6'b100000
    } phase_t;

endpackage

// ===== rtl/wsd_in_if.sv =====
interface wsd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] stream_byte;

    modport source (output valid, output stream_byte, input ready);
    modport sink (input valid, input stream_byte, output ready);
endinterface

// ===== rtl/wsd_out_if.sv =====
interface wsd_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic [7:0] payload_byte;
    logic       msg_start;
    logic       msg_end;

    modport source (output valid, output kind, output payload_byte, output msg_start,
                    output msg_end, input ready);
    modport sink (input valid, input kind, input payload_byte, input msg_start,
                  input msg_end, output ready);
endinterface

// ===== rtl/websocket_frame_deframer_core.sv =====
// websocket frame deframer
// rx carries the received connection bytes after the upgrade handshake, one
// byte per word. evt carries the results: payload bytes of text and
// continuation frames (unmasked, with message start and end marks), empty
// message boundaries, pong requests and a close event.
// each rx word is parsed in the cycle it is taken; a result, if the byte
// causes one, is shown on evt in the following cycle.
// one rx word is taken per cycle for as long as the evt side keeps up; the
// rate is set by the single result register, which is refilled in the same
// cycle it is drained.
// when evt stalls with a result held, rx.ready drops until it is taken.
// reset puts the parser at the first header byte of a new frame with no
// result pending. after a close frame every byte is taken and dropped until
// the next reset.
`include "assert_macros.svh"

module websocket_frame_deframer_core (
    input  logic          clk,
    input  logic          rst_n,
    wsd_in_if.sink        rx,
    wsd_out_if.source     evt
);
    import wsd_pkg::*;

    // parser state
    phase_t                 phase_reg, phase_next;
    logic                   fin_reg, fin_next;
    logic [3:0]             opcode_reg, opcode_next;
    logic                   mask_reg, mask_next;
    logic [LENGTH_BITS-1:0] len_reg, len_next;
    logic [31:0]            key_reg, key_next;
    logic [3:0]             ext_left_reg, ext_left_next;
    logic                   first_reg, first_next;

    // result register
    logic                   evt_valid_reg, evt_valid_next;
    kind_t                  kind_reg;
    logic [7:0]             data_reg;
    logic                   start_reg;
    logic                   end_reg;

    // per-byte work
    logic                   accept;
    logic [7:0]             b;
    logic [LENGTH_BITS-1:0] len_shift;
    logic                   data_op;
    logic                   done;
    logic                   done_empty;
    logic                   res_valid;
    kind_t                  res_kind;
    logic [7:0]             res_data;
    logic                   res_start;
    logic                   res_end;

    assign accept   = rx.valid && rx.ready;
    assign rx.ready = !evt_valid_reg || evt.ready;
    assign b        = rx.stream_byte;
    assign data_op  = (opcode_reg == OP_TEXT) || (opcode_reg == OP_CONT);

    // extended length shift with saturation
    assign len_shift = (len_reg[LENGTH_BITS-1 -: 8] != 8'd0) ? {LENGTH_BITS{1'b1}}
                                                             : {len_reg[LENGTH_BITS-9:0], b};

    // next state and result for one byte
    always_comb
    begin
        phase_next    = phase_reg;
        fin_next      = fin_reg;
        opcode_next   = opcode_reg;
        mask_next     = mask_reg;
        len_next      = len_reg;
        key_next      = key_reg;
        ext_left_next = ext_left_reg;
        first_next    = first_reg;
        done          = 1'b0;
        done_empty    = 1'b0;
        res_valid     = 1'b0;
        res_kind      = KIND_PAYLOAD;
        res_data      = 8'd0;
        res_start     = 1'b0;
        res_end       = 1'b0;

        unique case (phase_reg)
            PH_HDR0:
            begin
                fin_next    = b[7];
                opcode_next = b[3:0];
                phase_next  = PH_HDR1;
            end
            PH_HDR1:
            begin
                mask_next = b[7];
                key_next  = 32'd0;
                if ((b[6:0] == LEN7_EXT16) || (b[6:0] == LEN7_EXT64))
                begin
                    len_next      = '0;
                    ext_left_next = (b[6:0] == LEN7_EXT16) ? EXT16_BYTES : EXT64_BYTES;
                    phase_next    = PH_EXT;
                end
                else
                begin
                    len_next = LENGTH_BITS'(b[6:0]);
                    if (b[7])
                    begin
                        ext_left_next = KEY_BYTES;
                        phase_next    = PH_KEY;
                    end
                    else
                    begin
                        first_next = 1'b1;
                        if (b[6:0] == 7'd0)
                        begin
                            done       = 1'b1;
                            done_empty = 1'b1;
                        end
                        else
                        begin
                            phase_next = PH_DATA;
                        end
                    end
                end
            end
            PH_EXT:
            begin
                len_next      = len_shift;
                ext_left_next = ext_left_reg - 4'd1;
                if (ext_left_reg == 4'd1)
                begin
                    if (mask_reg)
                    begin
                        ext_left_next = KEY_BYTES;
                        phase_next    = PH_KEY;
                    end
                    else
                    begin
                        first_next = 1'b1;
                        if (len_shift == '0)
                        begin
                            done       = 1'b1;
                            done_empty = 1'b1;
                        end
                        else
                        begin
                            phase_next = PH_DATA;
                        end
                    end
                end
            end
            PH_KEY:
            begin
                key_next      = {key_reg[23:0], b};
                ext_left_next = ext_left_reg - 4'd1;
                if (ext_left_reg == 4'd1)
                begin
                    first_next = 1'b1;
                    if (len_reg == '0)
                    begin
                        done       = 1'b1;
                        done_empty = 1'b1;
                    end
                    else
                    begin
                        phase_next = PH_DATA;
                    end
                end
            end
            PH_DATA:
            begin
                // key byte in use sits on top, rotate for the next byte
                key_next   = {key_reg[23:0], key_reg[31:24]};
                first_next = 1'b0;
                len_next   = len_reg - LENGTH_BITS'(1);
                if (data_op)
                begin
                    res_valid = 1'b1;
                    res_kind  = KIND_PAYLOAD;
                    res_data  = mask_reg ? (b ^ key_reg[31:24]) : b;
                    res_start = first_reg && (opcode_reg == OP_TEXT);
                    res_end   = (len_reg == LENGTH_BITS'(1)) && fin_reg;
                    if (len_reg == LENGTH_BITS'(1))
                    begin
                        phase_next = PH_HDR0;
                    end
                end
                else if (len_reg == LENGTH_BITS'(1))
                begin
                    done = 1'b1;
                end
            end
            PH_CLOSED:
            begin
                phase_next = PH_CLOSED;
            end
            default:
            begin
                phase_next = PH_HDR0;
            end
        endcase

        // end of frame: control results and empty message boundaries
        if (done)
        begin
            phase_next = PH_HDR0;
            priority if (opcode_reg == OP_CLOSE)
            begin
                phase_next = PH_CLOSED;
                res_valid  = 1'b1;
                res_kind   = KIND_CLOSE;
            end
            else if (opcode_reg == OP_PING)
            begin
                res_valid = 1'b1;
                res_kind  = KIND_PONG;
            end
            else if (done_empty && data_op)
            begin
                res_valid = 1'b1;
                res_kind  = KIND_BOUNDARY;
                res_start = (opcode_reg == OP_TEXT);
                res_end   = fin_reg;
            end
            else
            begin
                res_valid = 1'b0;
            end
        end
    end

    // parser state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_HDR0;
            fin_reg      <= 1'b0;
            opcode_reg   <= 4'd0;
            mask_reg     <= 1'b0;
            len_reg      <= '0;
            key_reg      <= 32'd0;
            ext_left_reg <= 4'd0;
            first_reg    <= 1'b0;
        end
        else if (accept)
        begin
            phase_reg    <= phase_next;
            fin_reg      <= fin_next;
            opcode_reg   <= opcode_next;
            mask_reg     <= mask_next;
            len_reg      <= len_next;
            key_reg      <= key_next;
            ext_left_reg <= ext_left_next;
            first_reg    <= first_next;
        end
    end

    // result valid
    always_comb
    begin
        evt_valid_next = evt_valid_reg;
        if (accept)
        begin
            evt_valid_next = res_valid;
        end
        else if (evt.ready)
        begin
            evt_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            evt_valid_reg <= 1'b0;
        end
        else
        begin
            evt_valid_reg <= evt_valid_next;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (accept && res_valid)
        begin
            kind_reg  <= res_kind;
            data_reg  <= res_data;
            start_reg <= res_start;
            end_reg   <= res_end;
        end
    end

    assign evt.valid        = evt_valid_reg;
    assign evt.kind         = kind_reg;
    assign evt.payload_byte = data_reg;
    assign evt.msg_start    = start_reg;
    assign evt.msg_end      = end_reg;

    // checks
    `WSD_ASSERT(a_phase_onehot, clk, rst_n, $onehot(phase_reg))
    `WSD_ASSERT_NEXT(a_closed_sticks, clk, rst_n, phase_reg == PH_CLOSED, phase_reg == PH_CLOSED)
    `WSD_ASSERT(a_data_len_nonzero, clk, rst_n, (phase_reg != PH_DATA) || (len_reg != '0))
    `WSD_ASSERT(a_ctrl_no_marks, clk, rst_n, !evt_valid_reg || (kind_reg != KIND_PONG && kind_reg != KIND_CLOSE) || (!start_reg && !end_reg))
    `WSD_ASSERT(a_close_then_closed, clk, rst_n, !evt_valid_reg || (kind_reg != KIND_CLOSE) || (phase_reg == PH_CLOSED))

endmodule
